// ===== sv/pvs_pkg.sv =====
// Shared types, constants and helper functions for the purge valve scheduler.
`timescale 1ns / 1ps

package pvs_pkg;

  // Number of ticks between cell voltage difference checks.
  localparam int CHECK_PERIOD = 60;

  // Configuration register indexes.
  localparam logic [2:0] REG_INTERVAL_TABLE = 3'd0;
  localparam logic [2:0] REG_CURRENT_THRESH = 3'd1;
  localparam logic [2:0] REG_PURGE_LENGTH   = 3'd2;
  localparam logic [2:0] REG_VDIFF_LIMIT    = 3'd3;
  localparam logic [2:0] REG_OVERPRESS_L4   = 3'd4;
  localparam logic [2:0] REG_OVERPRESS_L3   = 3'd5;

  // Purge mode codes; any value above MODE_MANUAL is a fixed purge length.
  localparam logic [7:0] MODE_AUTO   = 8'd0;
  localparam logic [7:0] MODE_MANUAL = 8'd1;
  localparam logic [7:0] MODE_FORCED = 8'd4;

  // Pressure fault codes.
  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_UNDER_L4 = 3'd1;
  localparam logic [2:0] FAULT_UNDER_L3 = 3'd2;
  localparam logic [2:0] FAULT_OVER_L4  = 3'd3;
  localparam logic [2:0] FAULT_OVER_L3  = 3'd4;

  // Fixed pressure levels in 0.1 kPa absolute.
  localparam logic [15:0] PRESS_NORMAL_HI = 16'd2300;
  localparam logic [15:0] PRESS_NORMAL_LO = 16'd950;
  localparam logic [15:0] PRESS_UNDER_L4  = 16'd700;
  localparam logic [15:0] PRESS_UNDER_L3  = 16'd800;
  localparam logic [15:0] PRESS_LOW       = 16'd900;
  localparam logic [15:0] PRESS_OFFSET    = 16'd1000;

  // Voltage difference sanity cap and start-up behavior.
  localparam logic [15:0] VDIFF_CAP      = 16'd2000;
  localparam logic [11:0] STARTUP_TICKS  = 12'd30;
  localparam logic [3:0]  STARTUP_STATE  = 4'h7;

  // One input item.
  typedef struct packed {
    logic [4:0]  sys_status;
    logic [15:0] stack_current;
    logic [15:0] pressure_a;
    logic [15:0] pressure_b;
    logic [15:0] vdiff_a;
    logic [15:0] vdiff_b;
    logic        inlet_open;
    logic        auto_enabled;
    logic        protect_ready;
    logic        fault_armed;
    logic        mode_load;
    logic [7:0]  mode_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       valve_open;
    logic       aux_close;
    logic [2:0] fault_code;
    logic       level3_clear;
    logic [7:0] purge_mode;
  } out_item_t;

  // Configuration in the form the tick logic uses it.
  typedef struct packed {
    logic [6:0][11:0]   ticks;      // interval table entries in ticks
    logic signed [18:0] band1;
    logic signed [18:0] band2;
    logic signed [18:0] band3;
    logic signed [18:0] band4;
    logic signed [18:0] band5;
    logic signed [18:0] band6;
    logic [7:0]         open_ticks;
    logic [15:0]        vdiff_limit;
    logic [16:0]        lim4;
    logic [16:0]        lim3;
  } cfg_t;

  // Multiply an 8-bit count of seconds by ten.
  function automatic logic [11:0] times10_8(input logic [7:0] v);
    logic [11:0] w;
    w = {4'b0, v};
    return (w << 3) + (w << 1);
  endfunction

  // Turn an over-pressure setting into its absolute threshold.
  function automatic logic [16:0] press_limit(input logic [12:0] v);
    logic [16:0] w;
    w = {4'b0, v};
    return (w << 3) + (w << 1) + {1'b0, PRESS_OFFSET};
  endfunction

  // Purge length in ticks: divide by ten and saturate at 255.
  function automatic logic [7:0] open_len(input logic [11:0] v);
    logic [27:0] prod;
    logic [8:0]  q;
    prod = 28'(v) * 28'(52429);
    q = prod[27:19];
    return q[8] ? 8'hFF : q[7:0];
  endfunction

endpackage

// ===== sv/pvs_cfg.sv =====
// Configuration registers, kept in the pre-scaled form the tick logic needs.
`timescale 1ns / 1ps

module pvs_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output pvs_pkg::cfg_t        cfg
);
  import pvs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  cfg_t cfg_rst;

  logic [15:0] t0, t1, t2, t3;
  logic [18:0] t2x2, t3x2;

  // Threshold fields of the write data and the doubled upper two.
  assign t0   = cfg_data[15:0];
  assign t1   = cfg_data[31:16];
  assign t2   = cfg_data[47:32];
  assign t3   = cfg_data[63:48];
  assign t2x2 = {2'b0, t2, 1'b0};
  assign t3x2 = {2'b0, t3, 1'b0};

  // Reset value matches all raw registers at zero.
  always_comb begin
    cfg_rst             = '0;
    cfg_rst.band1       = -19'sd2;
    cfg_rst.band2       = -19'sd2;
    cfg_rst.band3       = -19'sd2;
    cfg_rst.band4       = -19'sd2;
    cfg_rst.band5       = 19'sd48;
    cfg_rst.band6       = 19'sd98;
    cfg_rst.lim4        = {1'b0, PRESS_OFFSET};
    cfg_rst.lim3        = {1'b0, PRESS_OFFSET};
  end

  // Decode a register write into its derived fields.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL_TABLE: begin
          for (int i = 0; i < 7; i++) begin
            cfg_nxt.ticks[i] = times10_8(cfg_data[8*i +: 8]);
          end
        end
        REG_CURRENT_THRESH: begin
          cfg_nxt.band1 = $signed({3'b0, t0}) - 19'sd2;
          cfg_nxt.band2 = $signed({3'b0, t1}) - 19'sd2;
          cfg_nxt.band3 = $signed(t2x2) - 19'sd2;
          cfg_nxt.band4 = $signed(t3x2) - 19'sd2;
          cfg_nxt.band5 = $signed(t3x2) + 19'sd48;
          cfg_nxt.band6 = $signed(t3x2) + 19'sd98;
        end
        REG_PURGE_LENGTH:  cfg_nxt.open_ticks  = open_len(cfg_data[11:0]);
        REG_VDIFF_LIMIT:   cfg_nxt.vdiff_limit = cfg_data[15:0];
        REG_OVERPRESS_L4:  cfg_nxt.lim4        = press_limit(cfg_data[12:0]);
        REG_OVERPRESS_L3:  cfg_nxt.lim3        = press_limit(cfg_data[12:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_rst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/pvs_core.sv =====
// Per-tick scheduler state and its combinational update.
`timescale 1ns / 1ps

module pvs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  pvs_pkg::in_item_t  item,
  input  pvs_pkg::cfg_t      cfg,
  output pvs_pkg::out_item_t result
);
  import pvs_pkg::*;

  logic [7:0]  mode_r, mode_nxt;
  logic [15:0] itimer_r, itimer_nxt;
  logic        oflag_r, oflag_nxt;
  logic [7:0]  otimer_r, otimer_nxt;
  logic [15:0] ftimer_r, ftimer_nxt;
  logic [5:0]  cdiv_r, cdiv_nxt;
  logic        valve_r, valve_nxt;

  logic [11:0]        interval;
  logic signed [18:0] cur_s;
  logic               low_a, low_b;
  logic [16:0]        pa_w, pb_w;
  logic [2:0]         fault;
  logic               l3clr;
  logic               aux;
  logic signed [12:0] pull;
  logic [12:0]        close_at;

  assign cur_s    = $signed({3'b0, item.stack_current});
  assign pull     = $signed({1'b0, interval}) - $signed({5'b0, cfg.open_ticks}) - 13'sd1;
  assign close_at = {1'b0, interval} + {5'b0, cfg.open_ticks};
  assign low_a    = item.pressure_a < PRESS_LOW;
  assign low_b    = item.pressure_b < PRESS_LOW;
  assign pa_w     = {1'b0, item.pressure_a};
  assign pb_w     = {1'b0, item.pressure_b};

  // Next state for one tick, in the order the scheduler applies its rules.
  always_comb begin
    mode_nxt   = item.mode_load ? item.mode_value : mode_r;
    itimer_nxt = itimer_r;
    oflag_nxt  = oflag_r;
    otimer_nxt = otimer_r;
    ftimer_nxt = ftimer_r;
    valve_nxt  = valve_r;
    fault      = FAULT_NONE;
    l3clr      = 1'b0;
    aux        = 1'b0;

    // Purge interval from start-up state, which also forces auto mode, or from current band.
    priority if (item.sys_status[3:0] == STARTUP_STATE) begin
      mode_nxt = MODE_AUTO;
      interval = STARTUP_TICKS;
    end else if (cur_s < cfg.band1) begin
      interval = cfg.ticks[0];
    end else if (cur_s >= cfg.band6) begin
      interval = cfg.ticks[6];
    end else if (cur_s >= cfg.band5) begin
      interval = cfg.ticks[5];
    end else if (cur_s >= cfg.band4) begin
      interval = cfg.ticks[4];
    end else if (cur_s >= cfg.band3) begin
      interval = cfg.ticks[3];
    end else if (cur_s >= cfg.band2) begin
      interval = cfg.ticks[2];
    end else begin
      interval = cfg.ticks[1];
    end

    // Pressure protection.
    if (item.protect_ready) begin
      l3clr = (item.pressure_a < PRESS_NORMAL_HI) && (item.pressure_b < PRESS_NORMAL_HI) &&
              (item.pressure_a >= PRESS_NORMAL_LO) && (item.pressure_b >= PRESS_NORMAL_LO);
      priority if (item.pressure_a < PRESS_UNDER_L4 || item.pressure_b < PRESS_UNDER_L4) begin
        fault    = FAULT_UNDER_L4;
        mode_nxt = MODE_FORCED;
      end else if (item.pressure_a < PRESS_UNDER_L3 || item.pressure_b < PRESS_UNDER_L3) begin
        fault    = FAULT_UNDER_L3;
        mode_nxt = MODE_FORCED;
      end else if (low_a || low_b) begin
        mode_nxt = MODE_FORCED;
      end else if (pa_w >= cfg.lim4 || pb_w >= cfg.lim4) begin
        if (item.fault_armed) begin
          fault = FAULT_OVER_L4;
        end
        mode_nxt = MODE_FORCED;
      end else if (pa_w >= cfg.lim3 || pb_w >= cfg.lim3) begin
        fault    = FAULT_OVER_L3;
        mode_nxt = MODE_FORCED;
      end else begin
      end
    end

    // Periodic voltage difference check pulls the next purge forward.
    cdiv_nxt = cdiv_r + 6'd1;
    if (cdiv_nxt >= 6'(CHECK_PERIOD)) begin
      cdiv_nxt = '0;
      if ((item.vdiff_a < VDIFF_CAP || item.vdiff_b < VDIFF_CAP) &&
          (item.vdiff_a > cfg.vdiff_limit || item.vdiff_b > cfg.vdiff_limit)) begin
        itimer_nxt = pull[12] ? 16'd0 : {4'b0, pull[11:0]};
      end
    end

    // Valve drive.
    if (item.inlet_open) begin
      // Fixed-length purge.
      if (mode_nxt > MODE_MANUAL) begin
        valve_nxt  = 1'b1;
        ftimer_nxt = ftimer_r + 16'd1;
        if (ftimer_nxt >= {8'b0, mode_nxt}) begin
          ftimer_nxt = '0;
          valve_nxt  = 1'b0;
          itimer_nxt = '0;
          mode_nxt   = item.auto_enabled ? MODE_MANUAL : MODE_AUTO;
        end
      end
      // Auto purge on the interval timer.
      if (mode_nxt == MODE_AUTO) begin
        itimer_nxt = itimer_nxt + 16'd1;
        if (itimer_nxt == {4'b0, interval}) begin
          valve_nxt = 1'b1;
          oflag_nxt = 1'b1;
        end else if (itimer_nxt >= {3'b0, close_at}) begin
          valve_nxt  = 1'b0;
          itimer_nxt = '0;
          oflag_nxt  = 1'b0;
          otimer_nxt = '0;
        end
        if (oflag_nxt) begin
          if (otimer_nxt != 8'hFF) begin
            otimer_nxt = otimer_nxt + 8'd1;
          end
          if (otimer_nxt > cfg.open_ticks) begin
            valve_nxt = 1'b0;
          end
        end
      end
    end else begin
      // Inlet shut: vent on low pressure, otherwise close and go manual.
      if (low_a || low_b) begin
        valve_nxt = 1'b1;
      end else begin
        mode_nxt  = MODE_MANUAL;
        valve_nxt = 1'b0;
        aux       = 1'b1;
      end
    end

    result.valve_open   = valve_nxt;
    result.aux_close    = aux;
    result.fault_code   = fault;
    result.level3_clear = l3clr;
    result.purge_mode   = mode_nxt;
  end

  // State registers advance once per transferred item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MANUAL;
      itimer_r <= '0;
      oflag_r  <= 1'b0;
      otimer_r <= '0;
      ftimer_r <= '0;
      cdiv_r   <= '0;
      valve_r  <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      itimer_r <= itimer_nxt;
      oflag_r  <= oflag_nxt;
      otimer_r <= otimer_nxt;
      ftimer_r <= ftimer_nxt;
      cdiv_r   <= cdiv_nxt;
      valve_r  <= valve_nxt;
    end
  end

endmodule

// ===== sv/purge_valve_scheduler.sv =====
// Top level of the purge valve scheduler: input register, tick update and result register.
`timescale 1ns / 1ps

// One input item is one 100 ms control tick. The block accepts one item per clock while
// in_stall is low and passes each result through its input and result registers in turn:
// an input register feeds a combinational update of the scheduler state, and the result
// is held in an output register so a new tick can be taken while a result waits.
// A stall on the output side holds the result and, once the input register is also
// full, stalls the input. Configuration writes take effect on the next clock and are
// meant to be made while no tick is in flight. After reset the purge mode is manual,
// all timers are zero and the valve is closed.
module purge_valve_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pvs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pvs_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import pvs_pkg::*;

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      advance;
  cfg_t      cfg;
  out_item_t result;

  // Configuration registers.
  pvs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Scheduler state update.
  pvs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // The held item moves on when the result register is free or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A held item always produces a result on the next clock when the output is free.
  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("held item did not reach the result register");

  // Fault codes stay within the defined set.
  a_fault_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fault_code <= FAULT_OVER_L3))
    else $error("fault code out of range");

  // Closing the second outlet means the valve is shut and the mode is manual.
  a_aux_close_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.aux_close) |->
      (!out_data_r.valve_open && out_data_r.purge_mode == MODE_MANUAL))
    else $error("second outlet closed with inconsistent valve state");

  // The input side is stalled only while the result register is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

endmodule
